// ===== rtl/api_transmit_request_framer_defines.svh =====
// assertion macros shared by the transmit-request framer modules
`ifndef API_TRANSMIT_REQUEST_FRAMER_DEFINES_SVH
`define API_TRANSMIT_REQUEST_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ATF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer check failed");
// antecedent implies consequent in the next cycle
`define ATF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer check failed");
`else
`define ATF_ASSERT_NOW(label, ante, cons)
`define ATF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/atf_pkg.sv =====
// types, constants and frame layout for the transmit-request framer
package atf_pkg;

  // request kinds
  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  // fixed frame bytes
  localparam logic [7:0]  ByteDelim     = 8'h7E;
  localparam logic [7:0]  ByteFrameType = 8'h10;
  localparam logic [7:0]  ByteFrameId   = 8'h00;
  localparam logic [7:0]  ByteAddrHi    = 8'hFF;
  localparam logic [7:0]  ByteAddrLo    = 8'hFE;
  localparam logic [7:0]  ByteOption    = 8'h00;
  localparam logic [7:0]  FixedSum      = 8'h0D;
  localparam logic [15:0] LenExtra      = 16'd14;

  // largest payload length carried in a frame
  localparam int MaxPayload = 255;
  localparam logic [15:0] MaxPayloadW = 16'(MaxPayload);

  // default depth of the command queue
  localparam int QueueDepthDef = 4;

  // header byte positions
  localparam logic [4:0] HdrDelim     = 5'd0;
  localparam logic [4:0] HdrLenHi     = 5'd1;
  localparam logic [4:0] HdrLenLo     = 5'd2;
  localparam logic [4:0] HdrType      = 5'd3;
  localparam logic [4:0] HdrId        = 5'd4;
  localparam logic [4:0] HdrDestFirst = 5'd5;
  localparam logic [4:0] HdrDestLast  = 5'd12;
  localparam logic [4:0] HdrAddrHi    = 5'd13;
  localparam logic [4:0] HdrAddrLo    = 5'd14;
  localparam logic [4:0] HdrLast      = 5'd16;

  typedef struct packed {
    logic        op;
    logic [63:0] dest_addr;
    logic [7:0]  payload_length;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } rsp_t;

  // command handed from front to back
  typedef struct packed {
    logic        is_start;
    logic        last;
    logic [63:0] dest;
    logic [7:0]  len;
    logic [7:0]  data;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_FETCH,
    BK_HDR,
    BK_CSUM
  } bk_state_t;

endpackage

// ===== rtl/atf_front.sv =====
// front end: accepts requests, tracks the open frame and issues commands
module atf_front
  import atf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  req_t req,
  output logic push,
  output cmd_t cmd
);

  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [7:0] len_c;

  // clamp the requested length
  assign len_c = ({8'h00, req.payload_length} > MaxPayloadW) ? MaxPayloadW[7:0]
                                                           : req.payload_length;

  // classify the request
  always_comb begin
    cmd.is_start = (req.op == OpStart);
    cmd.dest     = req.dest_addr;
    cmd.len      = len_c;
    cmd.data     = req.data_byte;
    if (req.op == OpStart) begin
      cmd.last = (len_c == 8'd0);
      push     = accept;
    end else begin
      cmd.last = (bytes_left == 8'd1);
      push     = accept && (bytes_left != 8'd0);
    end
  end

  // payload bytes still awaited in the open frame
  always_comb begin
    bytes_left_next = bytes_left;
    if (accept) begin
      if (req.op == OpStart) begin
        bytes_left_next = len_c;
      end else if (bytes_left != 8'd0) begin
        bytes_left_next = bytes_left - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 8'd0;
    end else begin
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ===== rtl/atf_fifo.sv =====
// short command queue between front and back
`include "api_transmit_request_framer_defines.svh"
module atf_fifo
  import atf_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign full     = (count == FullCnt);
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  `ATF_ASSERT_NOW(a_no_push_full, push, !full)
  `ATF_ASSERT_NOW(a_no_pop_empty, pop, nonempty)

endmodule

// ===== rtl/atf_back.sv =====
// back end: expands commands into frame bytes and keeps the checksum
`include "api_transmit_request_framer_defines.svh"
module atf_back
  import atf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic nonempty,
  input  cmd_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_rsp
);

  bk_state_t  state;
  bk_state_t  state_next;
  logic [4:0] idx;
  logic [4:0] idx_next;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic       emit;
  rsp_t       rsp_next;
  logic       can_load;
  logic [15:0] total;
  logic [2:0] dsel;
  logic [7:0] dest_byte;
  logic [7:0] hdr_byte;

  assign can_load = !out_valid || !out_stall;

  // header byte selection
  assign total     = {8'h00, head.len} + LenExtra;
  assign dsel      = 3'(idx - HdrDestFirst);
  assign dest_byte = head.dest[{~dsel, 3'b000} +: 8];

  always_comb begin
    if (idx inside {[HdrDestFirst:HdrDestLast]}) begin
      hdr_byte = dest_byte;
    end else begin
      case (idx)
        HdrDelim:  hdr_byte = ByteDelim;
        HdrLenHi:  hdr_byte = total[15:8];
        HdrLenLo:  hdr_byte = total[7:0];
        HdrType:   hdr_byte = ByteFrameType;
        HdrId:     hdr_byte = ByteFrameId;
        HdrAddrHi: hdr_byte = ByteAddrHi;
        HdrAddrLo: hdr_byte = ByteAddrLo;
        default:   hdr_byte = ByteOption;
      endcase
    end
  end

  // sequencer: next state and emitted byte
  always_comb begin
    state_next = state;
    idx_next   = idx;
    sum_next   = sum;
    emit       = 1'b0;
    pop        = 1'b0;
    rsp_next   = '0;
    case (state)
      BK_FETCH: begin
        if (nonempty && can_load) begin
          emit = 1'b1;
          if (head.is_start) begin
            rsp_next.out_byte = ByteDelim;
            sum_next          = FixedSum;
            idx_next          = HdrLenHi;
            state_next        = BK_HDR;
          end else begin
            rsp_next.out_byte = head.data;
            sum_next          = sum + head.data;
            pop               = 1'b1;
            if (head.last) begin
              state_next = BK_CSUM;
            end
          end
        end
      end
      BK_HDR: begin
        if (can_load) begin
          emit              = 1'b1;
          rsp_next.out_byte = hdr_byte;
          if (idx inside {[HdrDestFirst:HdrDestLast]}) begin
            sum_next = sum + dest_byte;
          end
          if (idx == HdrLast) begin
            pop        = 1'b1;
            idx_next   = HdrDelim;
            state_next = head.last ? BK_CSUM : BK_FETCH;
          end else begin
            idx_next = idx + 5'd1;
          end
        end
      end
      BK_CSUM: begin
        if (can_load) begin
          emit               = 1'b1;
          rsp_next.out_byte  = ~sum;
          rsp_next.frame_end = 1'b1;
          sum_next           = 8'h00;
          state_next         = BK_FETCH;
        end
      end
      default: begin
        state_next = BK_FETCH;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_FETCH;
      idx   <= HdrDelim;
      sum   <= 8'h00;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      sum   <= sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rsp <= rsp_next;
    end
  end

  `ATF_ASSERT_NEXT(a_csum_ends_frame, state == BK_CSUM && can_load,
                   out_valid && out_rsp.frame_end)
  `ATF_ASSERT_NOW(a_hdr_idx_range, state == BK_HDR,
                  idx >= HdrLenHi && idx <= HdrLast)
  `ATF_ASSERT_NOW(a_hdr_has_cmd, state == BK_HDR, nonempty && head.is_start)

endmodule

// ===== rtl/api_transmit_request_framer.sv =====
// Transmit-request framer (frame type 0x10), top level.
// The request channel (item_valid, item_stall, item) takes start requests
// (destination and payload length) and payload-byte requests. The frame
// channel (frame_valid, frame_stall, frame_out) gives one frame byte per
// transfer, with frame_end set on the closing checksum byte.
// A front end classifies requests and tracks the open frame, a command
// queue of QUEUE_DEPTH entries decouples it from a back-end sequencer,
// and the sequencer drives a registered output.
// With the queue empty and the sequencer idle, the first byte of a request
// passes the command queue and the output register to the frame channel.
// The sequencer emits one byte per cycle while frame_stall is low. A
// payload byte gives one frame byte, the last one of a frame two (byte
// and checksum); a start gives 17 bytes, 18 for a zero-length frame. Requests
// keep being taken while the queue has room, so payload passes at one byte per cycle.
// Payload requests with no frame open are taken and dropped. A start
// during an open frame ends that frame without a checksum.
// When frame_stall is high and a byte is valid, that byte holds and the
// sequencer waits; item_stall rises once the queue is full.
// Reset (rst, synchronous) empties the queue and closes any frame.
module api_transmit_request_framer
  import atf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  req_t item,
  output logic frame_valid,
  input  logic frame_stall,
  output rsp_t frame_out
);

  logic accept;
  logic push;
  cmd_t wr_cmd;
  logic pop;
  logic full;
  logic nonempty;
  cmd_t head;

  assign item_stall = full;
  assign accept     = item_valid && !item_stall;

  // request classification
  atf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (item),
    .push   (push),
    .cmd    (wr_cmd)
  );

  // command queue
  atf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_cmd   (wr_cmd),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  // byte sequencer
  atf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (frame_valid),
    .out_stall (frame_stall),
    .out_rsp   (frame_out)
  );

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the transmit-request framer with a built-in frame predictor
`timescale 1ns / 100ps

module tb;
  import atf_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int ReportLimit   = 10;
  localparam int TargetReqs    = 500;
  localparam int DrainCycles   = 20;
  localparam int IdlePercent   = 16;
  // requests in this range are sent and received with no idling at all
  localparam int QuietFirst    = 200;
  localparam int QuietLast     = 320;

  logic clk         = 1'b0;
  logic rst         = 1'b1;
  logic item_valid  = 1'b0;
  logic item_stall;
  req_t item        = '0;
  logic frame_valid;
  logic frame_stall = 1'b0;
  rsp_t frame_out;

  api_transmit_request_framer u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_out   (frame_out)
  );

  always #1 clk = ~clk;

  // predictor state: own copy of the open frame
  logic [7:0] payload_left  = '0;
  logic [7:0] csum_acc      = '0;
  logic       frame_is_open = 1'b0;

  rsp_t frame_bytes_due[$];
  req_t pending_reqs[$];
  rsp_t byte_due;

  logic req_taken   = 1'b0;
  int   reqs_taken  = 0;
  int   mismatches  = 0;
  int   idle_cycles = 0;
  int   n_items     = 0;
  logic quiet;

  assign quiet = (reqs_taken >= QuietFirst) && (reqs_taken < QuietLast);

  function automatic void due_byte(input logic [7:0] b, input logic last);
    frame_bytes_due.push_back(rsp_t'{out_byte: b, frame_end: last});
  endfunction

  // checksum closes the frame and clears the running state
  function automatic void close_frame();
    due_byte(~csum_acc, 1'b1);
    frame_is_open = 1'b0;
    payload_left  = '0;
    csum_acc      = '0;
  endfunction

  // expected frame bytes caused by one accepted request
  function automatic void predict_frame_bytes(input req_t r);
    logic [7:0]  len;
    logic [15:0] total;
    logic [7:0]  b;
    if (r.op == OpStart) begin
      len   = (int'(r.payload_length) > MaxPayload) ? MaxPayloadW[7:0] : r.payload_length;
      total = 16'(len) + LenExtra;
      due_byte(ByteDelim, 1'b0);
      due_byte(total[15:8], 1'b0);
      due_byte(total[7:0], 1'b0);
      due_byte(ByteFrameType, 1'b0);
      due_byte(ByteFrameId, 1'b0);
      csum_acc = FixedSum;
      for (int i = 7; i >= 0; i--) begin
        b = r.dest_addr[8*i +: 8];
        due_byte(b, 1'b0);
        csum_acc = csum_acc + b;
      end
      due_byte(ByteAddrHi, 1'b0);
      due_byte(ByteAddrLo, 1'b0);
      due_byte(ByteOption, 1'b0);
      due_byte(ByteOption, 1'b0);
      payload_left  = len;
      frame_is_open = 1'b1;
      if (payload_left == 0) close_frame();
    end else if (frame_is_open && payload_left != 0) begin
      due_byte(r.data_byte, 1'b0);
      csum_acc     = csum_acc + r.data_byte;
      payload_left = payload_left - 1'b1;
      if (payload_left == 0) close_frame();
    end
  endfunction

  function automatic logic [63:0] rand_dest();
    return {$urandom(), $urandom()};
  endfunction

  // unused fields carry random values so that they are shown to be ignored
  function automatic void queue_start(input logic [63:0] dest, input logic [7:0] len);
    pending_reqs.push_back(req_t'{op: OpStart, dest_addr: dest, payload_length: len,
                                  data_byte: 8'($urandom())});
    n_items++;
  endfunction

  function automatic void queue_data(input logic [7:0] b, input bit counted);
    pending_reqs.push_back(req_t'{op: OpData, dest_addr: rand_dest(),
                                  payload_length: 8'($urandom()), data_byte: b});
    if (counted) n_items++;
  endfunction

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      frame_stall <= 1'b0;
    end else begin
      if (!item_valid || req_taken) begin
        if (pending_reqs.size() != 0 &&
            (quiet || $urandom_range(0, 99) >= IdlePercent)) begin
          item       <= pending_reqs.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
      frame_stall <= !quiet && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // monitor: predict on accepted requests, check accepted frame bytes
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        req_taken = 1'b1;
        reqs_taken++;
        predict_frame_bytes(item);
      end
      if (frame_valid && !frame_stall) begin
        if (frame_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected frame byte: got byte %02h end %b",
                     frame_out.out_byte, frame_out.frame_end);
        end else begin
          byte_due = frame_bytes_due.pop_front();
          if (frame_out.out_byte !== byte_due.out_byte ||
              frame_out.frame_end !== byte_due.frame_end) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("frame byte mismatch: expected byte %02h end %b, got byte %02h end %b",
                       byte_due.out_byte, byte_due.frame_end,
                       frame_out.out_byte, frame_out.frame_end);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (frame_valid && !frame_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int         kind;
    int         shape;
    int         sent;
    logic [7:0] len;

    // payload with no frame open is dropped
    queue_data(8'hA5, 1'b0);
    // zero-length frame, all-ones destination
    queue_start('1, 8'd0);
    // single-byte frame, zero destination
    queue_start('0, 8'd1);
    queue_data(8'hFF, 1'b1);
    queue_start(64'h8000_0000_0000_0001, 8'd2);
    queue_data(8'h00, 1'b1);
    queue_data(8'h80, 1'b1);
    // stray byte after the checksum
    queue_data(8'h5A, 1'b0);
    // longest length, then cut short by a new start
    queue_start(64'h0123_4567_89AB_CDEF, 8'd255);
    repeat (3) queue_data(8'($urandom()), 1'b1);
    queue_start(rand_dest(), 8'd128);
    queue_data(8'($urandom()), 1'b1);
    queue_start(64'hFEDC_BA98_7654_3210, 8'd1);
    queue_data(8'h7E, 1'b1);
    queue_data(8'hFF, 1'b0);

    // random frames, mostly short and complete
    while (n_items < TargetReqs) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) len = 8'($urandom_range(0, 255));
      else if (kind < 13) len = 8'd0;
      else len = 8'($urandom_range(1, 8));
      queue_start(rand_dest(), len);
      shape = $urandom_range(0, 99);
      if (shape < 12 && len != 0) sent = $urandom_range(0, len - 1);
      else sent = len;
      repeat (sent) queue_data(8'($urandom()), 1'b1);
      // stray bytes only where no frame is left open
      if (sent == len && $urandom_range(0, 99) < 8)
        repeat ($urandom_range(1, 3)) queue_data(8'($urandom()), 1'b0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || item_valid) @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && frame_bytes_due.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== api_transmit_request_framer.f =====
+incdir+rtl
rtl/atf_pkg.sv
rtl/atf_front.sv
rtl/atf_fifo.sv
rtl/atf_back.sv
rtl/api_transmit_request_framer.sv
sim/tb.sv
